FILE: rtl/sra_pkg.sv
// Shared types, constants and helpers for the sensor report assembler.
package sra_pkg;

   localparam int NEIGHBOUR_SLOTS_DEF = 16;
   localparam int BYTE_W              = 8;
   localparam int ID_W                = 6;
   localparam int MCOUNT_W            = 6;
   localparam int HIST_W              = 64;
   localparam int CODE_W              = 2;

   localparam logic [MCOUNT_W-1:0] MOTION_MAX = 6'd32;
   localparam logic [ID_W-1:0]     ID_MOD     = 6'h3F;

   typedef enum logic [2:0] {
      FUNC_ADD_MOTION    = 3'd0,
      FUNC_ADD_NEIGHBOUR = 3'd1,
      FUNC_EMIT          = 3'd2,
      FUNC_NEW_MESSAGE   = 3'd3,
      FUNC_SET_ID        = 3'd4
   } func_type;

   typedef struct packed {
      logic add;
      logic clear;
      logic rd_en;
   } nbr_ctl_type;

   typedef struct packed {
      logic busy;
   } nbr_sts_type;

   // v mod 63 for v above 63; 64 == 1 (mod 63), so fold the top two bits in
   function automatic logic [ID_W-1:0] reduce_id(input logic [BYTE_W-1:0] v);
      logic [ID_W:0] s;
      s = {5'b0, v[7:6]} + {1'b0, v[5:0]};
      if (v[7:6] != 2'b00 && s >= {1'b0, ID_MOD}) begin
         s = s - {1'b0, ID_MOD};
      end
      return s[ID_W-1:0];
   endfunction

endpackage

FILE: rtl/sra_nbr_list.sv
// Neighbour list: synchronous memory, fill count and duplicate search.
module sra_nbr_list #(
   parameter int SLOTS = sra_pkg::NEIGHBOUR_SLOTS_DEF,
   parameter int CNT_W = $clog2(SLOTS + 1),
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sra_pkg::nbr_ctl_type      ctl,
   input  logic [sra_pkg::BYTE_W-1:0] add_id,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [sra_pkg::BYTE_W-1:0] rd_data,
   output sra_pkg::nbr_sts_type      sts,
   output logic [CNT_W-1:0]          count
);
   import sra_pkg::*;

   typedef enum logic [1:0] {
      NB_IDLE = 2'b01,
      NB_SCAN = 2'b10
   } nb_state_type;

   localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

   logic [BYTE_W-1:0] mem [SLOTS];

   nb_state_type      state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              cmp_ff, cmp_in;
   logic              found_ff, found_in;
   logic [BYTE_W-1:0] key_ff, key_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic              hit;

   assign hit = cmp_ff && (rd_data_ff == key_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      cmp_in   = 1'b0;
      found_in = found_ff;
      key_in   = key_ff;
      rd_en    = 1'b0;
      rd_idx   = rd_addr;
      wr_en    = 1'b0;
      wr_data  = add_id;
      unique case (state_ff)
         NB_IDLE: begin
            rd_en = ctl.rd_en;
            if (ctl.clear) begin
               count_in = '0;
            end else if (ctl.add) begin
               key_in = add_id;
               if (count_ff == '0) begin
                  // empty list: append straight away
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else if (count_ff != FULL) begin
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = NB_SCAN;
               end
            end
         end
         NB_SCAN: begin
            wr_data = key_ff;
            if (scan_ff != count_ff) begin
               rd_en   = 1'b1;
               rd_idx  = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
               cmp_in  = 1'b1;
            end
            found_in = found_ff | hit;
            // last compare lands the cycle after the last read
            if (cmp_ff && scan_ff == count_ff) begin
               if (!(found_ff | hit)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = NB_IDLE;
            end
         end
         default: state_in = NB_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NB_IDLE;
         count_ff <= '0;
         cmp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_ff   <= cmp_in;
      end
      scan_ff  <= scan_in;
      found_ff <= found_in;
      key_ff   <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data  = rd_data_ff;
   assign sts.busy = (state_ff == NB_SCAN);
   assign count    = count_ff;

endmodule

FILE: rtl/sensor_report_assembler.sv
// Sensor report assembler: motion history, neighbour list, message id, frame output.
// Add motion, new message, set id: applied on accept; the next word is taken on the next edge.
// Add neighbour: settled on accept for an empty or full list, else a duplicate search (one list read a cycle).
// Emit: accept enters the header state, which loads the first byte; then one byte a cycle through
// the header, motion and count bytes, memory read then load per neighbour byte, output stalls aside.
// Synchronous active-high reset clears history, counts, id and type code; list memory is not cleared.
module sensor_report_assembler #(
   parameter int NEIGHBOUR_SLOTS = sra_pkg::NEIGHBOUR_SLOTS_DEF,
   parameter int CNT_W           = $clog2(NEIGHBOUR_SLOTS + 1),
   parameter int IDX_W           = (NEIGHBOUR_SLOTS > 1) ? $clog2(NEIGHBOUR_SLOTS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   // request stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [1:0] motion_code, [9:2] neighbour_id, [17:10] node_id,
   // [25:18] temperature, [33:26] battery_level, [41:34] new_id, [47:42] zero
   input  logic [47:0]                req_tdata,
   // [2:0] func
   input  logic [2:0]                 req_tuser,
   // response stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [7:0] frame_byte
   output logic [sra_pkg::BYTE_W-1:0] rsp_tdata,
   // last_byte
   output logic                       rsp_tlast,
   // type code register
   input  logic                       csr_we,
   input  logic [sra_pkg::CODE_W-1:0] csr_wdata
);
   import sra_pkg::*;

   // one state per frame part; neighbour bytes alternate address and load
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_HEAD  = 10'b0000000010,
      S_NODE  = 10'b0000000100,
      S_TEMP  = 10'b0000001000,
      S_BATT  = 10'b0000010000,
      S_MCNT  = 10'b0000100000,
      S_MOT   = 10'b0001000000,
      S_NCNT  = 10'b0010000000,
      S_NADDR = 10'b0100000000,
      S_NLOAD = 10'b1000000000
   } state_type;

   // word fields
   logic [CODE_W-1:0] motion_code;
   logic [BYTE_W-1:0] neighbour_id, node_id, temperature, battery_level, new_id;
   logic [2:0]        func;

   assign motion_code   = req_tdata[1:0];
   assign neighbour_id  = req_tdata[9:2];
   assign node_id       = req_tdata[17:10];
   assign temperature   = req_tdata[25:18];
   assign battery_level = req_tdata[33:26];
   assign new_id        = req_tdata[41:34];
   assign func          = req_tuser;

   state_type           state_ff, state_in;
   logic [HIST_W-1:0]   hist_ff, hist_in;
   logic [MCOUNT_W-1:0] mcount_ff, mcount_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [CODE_W-1:0]   type_ff, type_in;

   // emit snapshot
   logic [BYTE_W-1:0]   node_ff, node_in;
   logic [BYTE_W-1:0]   temp_ff, temp_in;
   logic [BYTE_W-1:0]   batt_ff, batt_in;
   logic [HIST_W-1:0]   shist_ff, shist_in;
   logic [3:0]          mot_left_ff, mot_left_in;
   logic [CNT_W-1:0]    nidx_ff, nidx_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   nbr_ctl_type         nbr_ctl;
   nbr_sts_type         nbr_sts;
   logic [BYTE_W-1:0]   nbr_rd_data;
   logic [CNT_W-1:0]    nbr_count;

   logic                accept;
   logic                out_free;
   logic                load;
   logic [BYTE_W-1:0]   load_data;
   logic                load_last;
   logic [ID_W:0]       mot_sum;
   logic [3:0]          mot_bytes;
   logic [CNT_W-1:0]    nidx_next;

   assign req_tready = (state_ff == S_IDLE) && !nbr_sts.busy;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // ceil(count / 4), never below one byte
   assign mot_sum   = {1'b0, mcount_ff} + 7'd3;
   assign mot_bytes = (mot_sum[6:2] == '0) ? 4'd1 : mot_sum[5:2];
   assign nidx_next = nidx_ff + 1'b1;

   sra_nbr_list #(
      .SLOTS (NEIGHBOUR_SLOTS),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
   ) u_nbr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (nbr_ctl),
      .add_id  (neighbour_id),
      .rd_addr (nidx_ff[IDX_W-1:0]),
      .rd_data (nbr_rd_data),
      .sts     (nbr_sts),
      .count   (nbr_count)
   );

   always_comb begin
      state_in    = state_ff;
      hist_in     = hist_ff;
      mcount_in   = mcount_ff;
      id_in       = id_ff;
      type_in     = csr_we ? csr_wdata : type_ff;
      node_in     = node_ff;
      temp_in     = temp_ff;
      batt_in     = batt_ff;
      shist_in    = shist_ff;
      mot_left_in = mot_left_ff;
      nidx_in     = nidx_ff;
      nbr_ctl     = '0;
      load        = 1'b0;
      load_data   = '0;
      load_last   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_ADD_MOTION: begin
                     if (mcount_ff < MOTION_MAX) begin
                        mcount_in = mcount_ff + 1'b1;
                     end
                     hist_in = {hist_ff[HIST_W-CODE_W-1:0], motion_code};
                  end
                  FUNC_ADD_NEIGHBOUR: nbr_ctl.add = 1'b1;
                  FUNC_EMIT: begin
                     node_in     = node_id;
                     temp_in     = temperature;
                     batt_in     = battery_level;
                     shist_in    = hist_ff;
                     mot_left_in = mot_bytes;
                     state_in    = S_HEAD;
                  end
                  FUNC_NEW_MESSAGE: begin
                     hist_in       = '0;
                     mcount_in     = '0;
                     nbr_ctl.clear = 1'b1;
                     id_in         = reduce_id({2'b00, id_ff} + 8'd1);
                  end
                  FUNC_SET_ID: id_in = reduce_id(new_id);
                  default: ;
               endcase
            end
         end
         S_HEAD: begin
            load      = out_free;
            load_data = {id_ff, type_ff};
            if (out_free) state_in = S_NODE;
         end
         S_NODE: begin
            load      = out_free;
            load_data = node_ff;
            if (out_free) state_in = S_TEMP;
         end
         S_TEMP: begin
            load      = out_free;
            load_data = temp_ff;
            if (out_free) state_in = S_BATT;
         end
         S_BATT: begin
            load      = out_free;
            load_data = batt_ff;
            if (out_free) state_in = S_MCNT;
         end
         S_MCNT: begin
            load      = out_free;
            load_data = {2'b00, mcount_ff};
            if (out_free) state_in = S_MOT;
         end
         S_MOT: begin
            load      = out_free;
            load_data = shist_ff[BYTE_W-1:0];
            if (out_free) begin
               shist_in    = shist_ff >> BYTE_W;
               mot_left_in = mot_left_ff - 1'b1;
               if (mot_left_ff == 4'd1) state_in = S_NCNT;
            end
         end
         S_NCNT: begin
            load      = out_free;
            load_data = {{(BYTE_W-CNT_W){1'b0}}, nbr_count};
            load_last = (nbr_count == '0);
            if (out_free) begin
               nidx_in  = '0;
               state_in = (nbr_count == '0) ? S_IDLE : S_NADDR;
            end
         end
         S_NADDR: begin
            nbr_ctl.rd_en = 1'b1;
            state_in      = S_NLOAD;
         end
         S_NLOAD: begin
            // read data holds until the next read, so stalls are harmless
            load      = out_free;
            load_data = nbr_rd_data;
            load_last = (nidx_next == nbr_count);
            if (out_free) begin
               nidx_in  = nidx_next;
               state_in = (nidx_next == nbr_count) ? S_IDLE : S_NADDR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
         rsp_last_in  = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hist_ff      <= '0;
         mcount_ff    <= '0;
         id_ff        <= '0;
         type_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         mcount_ff    <= mcount_in;
         id_ff        <= id_in;
         type_ff      <= type_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      temp_ff     <= temp_in;
      batt_ff     <= batt_in;
      shist_ff    <= shist_in;
      mot_left_ff <= mot_left_in;
      nidx_ff     <= nidx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // an accepted emit always starts on the header byte
   a_emit_starts: assert property (@(posedge clock) disable iff (reset)
      accept && func == FUNC_EMIT |=> state_ff == S_HEAD)
      else $error("emit did not enter header state");

   // the list never grows past its slots
   a_nbr_bound: assert property (@(posedge clock) disable iff (reset)
      nbr_count <= CNT_W'(NEIGHBOUR_SLOTS))
      else $error("neighbour count beyond slots");

   // motion count saturates
   a_mcount_bound: assert property (@(posedge clock) disable iff (reset)
      mcount_ff <= MOTION_MAX)
      else $error("motion count beyond saturation");

   // no new word while the duplicate search runs
   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(accept && func == FUNC_ADD_NEIGHBOUR) && nbr_sts.busy |-> !req_tready)
      else $error("word taken during neighbour search");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the sensor report assembler: scoreboard model plus stream drivers.
module tb;
   import sra_pkg::*;

   // Function codes outside the defined set; the block must ignore them
   localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
   localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;
   localparam logic [1:0] TYPE_MIN        = 2'd0;
   localparam logic [1:0] TYPE_MAX        = 2'd3;

   localparam int ID_LIMIT         = 63;    // ids above this fold mod 63
   localparam int MOTION_CAP       = 32;    // motion count saturates here
   localparam int SETTLE_CYCLES    = 40;    // outlasts the worst neighbour search
   localparam int STALL_LIMIT      = 2000;  // watchdog: cycles with no word moving
   localparam int HOLD_CYCLES      = 400;   // one long receiver hold-off
   localparam int HOLD_AFTER_WORDS = 60;
   localparam int PHASE_WORDS      = 40;

   // One request word, fields at the block's widths
   typedef struct {
      logic [2:0] func;
      logic [1:0] code;
      logic [7:0] nbr;
      logic [7:0] node;
      logic [7:0] temp;
      logic [7:0] batt;
      logic [7:0] new_id;
   } sensor_word_type;

   typedef struct {
      logic [7:0] fbyte;
      logic       fend;
   } frame_byte_type;

   // Tracks the node state and queues the frame bytes that each emit must produce
   class frame_tracker;
      logic [63:0] history;
      logic [5:0]  motion_cnt;
      logic [7:0]  neighbours [NEIGHBOUR_SLOTS_DEF];
      int          nbr_cnt;
      logic [5:0]  msg_id;
      logic [1:0]  type_code;
      frame_byte_type expected_bytes [$];
      int          failures;

      function new();
         history    = '0;
         motion_cnt = '0;
         nbr_cnt    = 0;
         msg_id     = '0;
         type_code  = '0;
         failures   = 0;
      endfunction

      function logic [5:0] fold_id(int v);
         if (v > ID_LIMIT) begin
            v = v % ID_LIMIT;
         end
         return v[5:0];
      endfunction

      function void push_byte(logic [7:0] b);
         frame_byte_type e;
         e.fbyte = b;
         e.fend  = 1'b0;
         expected_bytes.push_back(e);
      endfunction

      function void note_request(sensor_word_type w);
         logic [63:0] h;
         int          nbytes;
         bit          found;
         frame_byte_type tail;
         case (w.func)
            FUNC_ADD_MOTION: begin
               if (motion_cnt < MOTION_CAP) begin
                  motion_cnt++;
               end
               history = {history[61:0], w.code};
            end
            FUNC_ADD_NEIGHBOUR: begin
               found = 1'b0;
               for (int i = 0; i < nbr_cnt; i++) begin
                  if (neighbours[i] == w.nbr) begin
                     found = 1'b1;
                  end
               end
               if (!found && nbr_cnt < NEIGHBOUR_SLOTS_DEF) begin
                  neighbours[nbr_cnt] = w.nbr;
                  nbr_cnt++;
               end
            end
            FUNC_EMIT: begin
               h      = history;
               nbytes = (motion_cnt + 3) / 4;
               if (nbytes == 0) begin
                  nbytes = 1;
               end
               push_byte({msg_id, type_code});
               push_byte(w.node);
               push_byte(w.temp);
               push_byte(w.batt);
               push_byte({2'b00, motion_cnt});
               for (int i = 0; i < nbytes; i++) begin
                  push_byte(h[7:0]);
                  h = h >> 8;
               end
               push_byte(nbr_cnt[7:0]);
               for (int i = 0; i < nbr_cnt; i++) begin
                  push_byte(neighbours[i]);
               end
               tail      = expected_bytes.pop_back();
               tail.fend = 1'b1;
               expected_bytes.push_back(tail);
            end
            FUNC_NEW_MESSAGE: begin
               history    = '0;
               motion_cnt = '0;
               nbr_cnt    = 0;
               msg_id     = fold_id(msg_id + 1);
            end
            FUNC_SET_ID: begin
               msg_id = fold_id(w.new_id);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_byte(logic [7:0] b, logic l);
         frame_byte_type e;
         if (expected_bytes.size() == 0) begin
            $error("frame_byte %02h arrived with nothing expected", b);
            failures++;
            return;
         end
         e = expected_bytes.pop_front();
         if (b !== e.fbyte) begin
            $error("frame_byte: expected %02h, got %02h", e.fbyte, b);
            failures++;
         end
         if (l !== e.fend) begin
            $error("last_byte: expected %0b, got %0b", e.fend, l);
            failures++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [47:0]       req_tdata;
   logic [2:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [BYTE_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we;
   logic [CODE_W-1:0] csr_wdata;

   frame_tracker sb;
   int           words_taken;
   int           idle_cycles;

   sensor_report_assembler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // [1:0] code, [9:2] neighbour, [17:10] node, [25:18] temp, [33:26] battery,
      // [41:34] new id, [47:42] zero
      .req_tdata  (req_tdata),
      // [2:0] func
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [7:0] frame byte
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mostly back-to-back, some short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic sensor_word_type random_word(logic [2:0] f);
      sensor_word_type w;
      w.func   = f;
      w.code   = 2'($urandom_range(0, 3));
      w.nbr    = 8'($urandom_range(0, 255));
      w.node   = 8'($urandom_range(0, 255));
      w.temp   = 8'($urandom_range(0, 255));
      w.batt   = 8'($urandom_range(0, 255));
      w.new_id = 8'($urandom_range(0, 255));
      return w;
   endfunction

   // Offer one word, hold it until taken, then maybe leave a gap.
   // Called at a rising edge; leaves the caller at a rising edge.
   task automatic send_word(sensor_word_type w);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= w.func;
      req_tdata  <= {6'b0, w.new_id, w.batt, w.temp, w.node, w.nbr, w.code};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(w);
      words_taken++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The one operand byte lands in neighbour and new id, its low two bits in code
   task automatic send_op(logic [2:0] f, logic [7:0] v);
      sensor_word_type w;
      w        = random_word(f);
      w.code   = v[1:0];
      w.nbr    = v;
      w.new_id = v;
      send_word(w);
   endtask

   task automatic send_emit(logic [7:0] node, logic [7:0] temp, logic [7:0] batt);
      sensor_word_type w;
      w      = random_word(FUNC_EMIT);
      w.node = node;
      w.temp = temp;
      w.batt = batt;
      send_word(w);
   endtask

   // Wait for every frame byte, then let any neighbour search finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_type(logic [1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.type_code = v;
   endtask

   // A realistic report: new message or id, a run of motion and neighbour words, emit.
   // Long runs push the motion count into saturation and fill the neighbour list;
   // small neighbour ids give plenty of duplicates.
   task automatic build_frame();
      int n_motion;
      int n_nbr;
      if ($urandom_range(0, 3) != 0) begin
         send_op(FUNC_NEW_MESSAGE, 8'($urandom_range(0, 255)));
      end else begin
         send_op(FUNC_SET_ID, 8'($urandom_range(0, 255)));
      end
      n_motion = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(20, 40);
      n_nbr    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(12, 20);
      while (n_motion + n_nbr > 0) begin
         if (n_nbr == 0 || (n_motion > 0 && $urandom_range(0, 1) == 1)) begin
            send_op(FUNC_ADD_MOTION, 8'($urandom_range(0, 3)));
            n_motion--;
         end else begin
            send_op(FUNC_ADD_NEIGHBOUR,
                    8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255)));
            n_nbr--;
         end
      end
      send_word(random_word(FUNC_EMIT));
   endtask

   // Mostly whole reports, the rest single noise words of any func code
   task automatic random_phase(int n);
      int start;
      start = words_taken;
      while (words_taken - start < n) begin
         if ($urandom_range(0, 9) < 8) begin
            build_frame();
         end else begin
            send_op(3'($urandom_range(FUNC_ADD_MOTION, FUNC_RSVD_LAST)),
                    8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Every accepted frame byte goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_byte(rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog: too long with no word moving on either side means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random ready runs and gaps; once, a long hold-off while the sender
   // keeps offering so the output backs up into the request side
   initial begin : receiver
      int  run;
      int  gap;
      bit  held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && words_taken >= HOLD_AFTER_WORDS) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         run = $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Sender and run control
   initial begin
      sb          = new();
      words_taken = 0;
      idle_cycles = 0;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, type code still at its reset value.
      // Empty history and list: one zero motion byte, zero neighbours.
      send_emit(8'hFF, 8'h00, 8'hFF);
      send_op(FUNC_ADD_MOTION, 8'd3);
      send_op(FUNC_ADD_MOTION, 8'd0);
      send_op(FUNC_ADD_MOTION, 8'd1);
      send_op(FUNC_ADD_MOTION, 8'd2);
      send_op(FUNC_ADD_NEIGHBOUR, 8'hFF);
      send_op(FUNC_ADD_NEIGHBOUR, 8'h00);
      send_op(FUNC_ADD_NEIGHBOUR, 8'hFF);      // duplicate, dropped
      send_emit(8'h00, 8'hFF, 8'h00);
      send_op(FUNC_SET_ID, 8'd255);            // folds to 3
      send_emit(8'hA5, 8'h5A, 8'hC3);
      send_op(FUNC_SET_ID, 8'd126);            // folds to 0
      send_op(FUNC_SET_ID, 8'd189);            // folds to 0
      send_op(FUNC_SET_ID, 8'd63);             // largest id kept as is
      send_op(FUNC_NEW_MESSAGE, 8'd0);         // 63 + 1 wraps to 1, state cleared
      send_emit(8'h3C, 8'hC3, 8'h81);
      send_op(FUNC_SET_ID, 8'd64);             // folds to 1
      send_op(FUNC_SET_ID, 8'd62);
      send_op(FUNC_NEW_MESSAGE, 8'd0);
      send_op(FUNC_NEW_MESSAGE, 8'd0);         // 63 again, then wrap
      send_emit(8'h7E, 8'h18, 8'hE7);
      send_op(FUNC_RSVD_FIRST, 8'hFF);         // ignored codes
      send_op(FUNC_RSVD_FIRST + 3'd1, 8'h00);
      send_op(FUNC_RSVD_LAST, 8'hAA);
      send_emit(8'h01, 8'h80, 8'h7F);

      // Random reports under several header type codes, extremes included
      wait_idle();
      write_type(TYPE_MAX);
      random_phase(PHASE_WORDS);
      wait_idle();
      write_type(TYPE_MIN);
      random_phase(PHASE_WORDS);
      wait_idle();
      write_type(2'd2);
      random_phase(PHASE_WORDS);
      wait_idle();
      write_type(2'd1);
      random_phase(PHASE_WORDS);

      wait_idle();
      if (sb.failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
